>>> src/mtc_pkg.sv
`timescale 1ns / 1ps

package mtc_pkg;

  // Sizing of the count matrix
  localparam int MAX_CATEGORIES = 8;
  localparam int COUNT_BITS     = 16;

  localparam int DEPTH   = MAX_CATEGORIES * MAX_CATEGORIES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int CAT_W   = $clog2(MAX_CATEGORIES + 1);

  // Fixed field widths
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 4;
  localparam int LABEL_W = 4;
  localparam int PAIR_W  = 16;
  localparam int WIDE_W  = (COUNT_BITS > PAIR_W) ? COUNT_BITS : PAIR_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              start;
    logic [CAT_W-1:0]  n;
    logic [CODE_W-1:0] first;
  } start_t;

  typedef enum logic [1:0] {
    RO_IDLE,
    RO_READ,
    RO_LOAD,
    RO_SEND
  } ro_state_t;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_CATEGORIES) + ADDR_W'(col);
  endfunction

  function automatic logic in_range(input logic [CODE_W-1:0] code,
                                    input logic [CAT_W-1:0]  n);
    return (code != '0) && (code <= CODE_W'(n));
  endfunction

  function automatic logic [PAIR_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    if (wide > WIDE_W'({PAIR_W{1'b1}})) begin
      return '1;
    end
    return PAIR_W'(wide);
  endfunction

endpackage

>>> src/mtc_if.sv
`timescale 1ns / 1ps

interface mtc_in_if;
  logic                      valid;
  logic                      ready;
  logic [mtc_pkg::CODE_W-1:0] sample_code;
  logic                      is_missing;
  logic [mtc_pkg::CODE_W-1:0] imputed_code;
  logic                      end_of_sequence;

  modport source(output valid, sample_code, is_missing, imputed_code, end_of_sequence,
                 input ready);
  modport sink(input valid, sample_code, is_missing, imputed_code, end_of_sequence,
               output ready);
endinterface

interface mtc_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtc_pkg::LABEL_W-1:0] from_category;
  logic [mtc_pkg::LABEL_W-1:0] to_category;
  logic [mtc_pkg::PAIR_W-1:0]  pair_count;
  logic [mtc_pkg::CODE_W-1:0]  first_code;
  logic                       last_entry;

  modport source(output valid, from_category, to_category, pair_count, first_code,
                 last_entry, input ready);
  modport sink(input valid, from_category, to_category, pair_count, first_code,
               last_entry, output ready);
endinterface

interface mtc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mtc_pkg::CFG_W-1:0] category_count;

  modport source(output valid, category_count, input ready);
  modport sink(input valid, category_count, output ready);
endinterface

>>> src/mtc_store.sv
`timescale 1ns / 1ps

module mtc_store (
  input  logic                           clk,
  input  logic                           rst,
  input  mtc_pkg::rd_req_t               rd,
  input  mtc_pkg::wr_req_t               wr,
  input  logic                           clear,
  output logic [mtc_pkg::COUNT_BITS-1:0] rd_data
);

  logic [mtc_pkg::COUNT_BITS-1:0] mem [mtc_pkg::DEPTH];
  logic [mtc_pkg::DEPTH-1:0]      written;
  logic [mtc_pkg::COUNT_BITS-1:0] rd_raw;
  logic                           rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_raw <= mem[rd.addr];
    end
  end

  // Entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_hit <= written[rd.addr];
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

>>> src/mtc_update.sv
`timescale 1ns / 1ps

module mtc_update (
  input  logic                           clk,
  input  logic                           rst,
  mtc_in_if.sink                         samples,
  input  logic [mtc_pkg::CAT_W-1:0]      n,
  input  logic                           ro_busy,
  input  logic [mtc_pkg::COUNT_BITS-1:0] rd_data,
  output mtc_pkg::rd_req_t               rd,
  output mtc_pkg::wr_req_t               wr,
  output mtc_pkg::start_t                start
);

  logic                           accept;
  logic [mtc_pkg::CODE_W-1:0]     code;
  logic                           pair_ok;
  logic [mtc_pkg::ADDR_W-1:0]     idx;

  logic                           have_prev;
  logic [mtc_pkg::CODE_W-1:0]     prev;
  logic [mtc_pkg::CODE_W-1:0]     first;

  // Update stage: read data arrives here, write back at the end
  logic                           b_valid;
  logic                           b_count;
  logic                           b_eos;
  logic [mtc_pkg::ADDR_W-1:0]     b_idx;
  logic [mtc_pkg::CAT_W-1:0]      b_n;
  logic [mtc_pkg::CODE_W-1:0]     b_first;
  logic                           b_fwd;
  logic [mtc_pkg::COUNT_BITS-1:0] fwd_val;
  logic [mtc_pkg::COUNT_BITS-1:0] old_val;
  logic [mtc_pkg::COUNT_BITS-1:0] new_val;

  assign samples.ready = !ro_busy && !(b_valid && b_eos);
  assign accept        = samples.valid && samples.ready;
  assign code          = samples.is_missing ? samples.imputed_code : samples.sample_code;
  assign pair_ok       = have_prev && mtc_pkg::in_range(prev, n) && mtc_pkg::in_range(code, n);
  assign idx           = mtc_pkg::entry_addr(mtc_pkg::ROW_W'(prev - mtc_pkg::CODE_W'(1)),
                                             mtc_pkg::ROW_W'(code - mtc_pkg::CODE_W'(1)));

  assign rd.en   = accept && pair_ok;
  assign rd.addr = idx;

  // Take the value just written when back-to-back requests hit one entry
  assign old_val = b_fwd ? fwd_val : rd_data;
  assign new_val = (old_val == mtc_pkg::COUNT_MAX) ? old_val
                                                   : old_val + mtc_pkg::COUNT_BITS'(1);

  assign wr.en   = b_valid && b_count;
  assign wr.addr = b_idx;
  assign wr.data = new_val;

  assign start.start = b_valid && b_eos;
  assign start.n     = b_n;
  assign start.first = b_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev      <= '0;
      first     <= '0;
    end else if (accept) begin
      if (samples.end_of_sequence) begin
        have_prev <= 1'b0;
        prev      <= '0;
        first     <= '0;
      end else begin
        have_prev <= 1'b1;
        prev      <= code;
        if (!have_prev) begin
          first <= code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_count <= pair_ok;
      b_eos   <= samples.end_of_sequence;
      b_idx   <= idx;
      b_n     <= n;
      b_first <= have_prev ? first : code;
      b_fwd   <= b_valid && b_count && (b_idx == idx);
      fwd_val <= new_val;
    end
  end

endmodule

>>> src/mtc_readout.sv
`timescale 1ns / 1ps

module mtc_readout (
  input  logic                           clk,
  input  logic                           rst,
  input  mtc_pkg::start_t                start,
  input  logic [mtc_pkg::COUNT_BITS-1:0] rd_data,
  output mtc_pkg::rd_req_t               rd,
  output logic                           clear,
  output logic                           busy,
  mtc_out_if.source                      results
);

  mtc_pkg::ro_state_t             state;
  mtc_pkg::ro_state_t             state_next;

  logic [mtc_pkg::ROW_W-1:0]      r;
  logic [mtc_pkg::ROW_W-1:0]      c;
  logic [mtc_pkg::ROW_W-1:0]      r_next;
  logic [mtc_pkg::ROW_W-1:0]      c_next;
  logic [mtc_pkg::CAT_W-1:0]      n_q;
  logic [mtc_pkg::CODE_W-1:0]     first_q;
  logic                           c_end;
  logic                           r_end;
  logic                           advance;

  logic [mtc_pkg::LABEL_W-1:0]    out_from;
  logic [mtc_pkg::LABEL_W-1:0]    out_to;
  logic [mtc_pkg::PAIR_W-1:0]     out_count;
  logic                           out_last;

  assign c_end   = (mtc_pkg::CAT_W'(c) + mtc_pkg::CAT_W'(1)) == n_q;
  assign r_end   = (mtc_pkg::CAT_W'(r) + mtc_pkg::CAT_W'(1)) == n_q;
  assign c_next  = c_end ? '0 : c + mtc_pkg::ROW_W'(1);
  assign r_next  = c_end ? r + mtc_pkg::ROW_W'(1) : r;
  assign advance = (state == mtc_pkg::RO_SEND) && results.ready;

  always_comb begin
    state_next = state;
    case (state)
      mtc_pkg::RO_IDLE: begin
        if (start.start && (start.n != '0)) begin
          state_next = mtc_pkg::RO_READ;
        end
      end
      mtc_pkg::RO_READ: state_next = mtc_pkg::RO_LOAD;
      mtc_pkg::RO_LOAD: state_next = mtc_pkg::RO_SEND;
      mtc_pkg::RO_SEND: begin
        if (results.ready) begin
          state_next = out_last ? mtc_pkg::RO_IDLE : mtc_pkg::RO_LOAD;
        end
      end
      default: state_next = mtc_pkg::RO_IDLE;
    endcase
  end

  always_comb begin
    rd.en   = 1'b0;
    rd.addr = mtc_pkg::entry_addr(r, c);
    clear   = 1'b0;
    case (state)
      mtc_pkg::RO_IDLE: clear = start.start && (start.n == '0);
      mtc_pkg::RO_READ: rd.en = 1'b1;
      mtc_pkg::RO_LOAD: rd.en = 1'b0;
      mtc_pkg::RO_SEND: begin
        // Fetch the next entry while the current one leaves
        rd.en   = results.ready && !out_last;
        rd.addr = mtc_pkg::entry_addr(r_next, c_next);
        clear   = results.ready && out_last;
      end
      default: rd.en = 1'b0;
    endcase
  end

  assign busy                  = (state != mtc_pkg::RO_IDLE);
  assign results.valid         = (state == mtc_pkg::RO_SEND);
  assign results.from_category = out_from;
  assign results.to_category   = out_to;
  assign results.pair_count    = out_count;
  assign results.first_code    = first_q;
  assign results.last_entry    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtc_pkg::RO_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == mtc_pkg::RO_IDLE) && start.start) begin
      r       <= '0;
      c       <= '0;
      n_q     <= start.n;
      first_q <= start.first;
    end else if (advance) begin
      r <= r_next;
      c <= c_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mtc_pkg::RO_LOAD) begin
      out_from  <= mtc_pkg::LABEL_W'(mtc_pkg::CAT_W'(r) + mtc_pkg::CAT_W'(1));
      out_to    <= mtc_pkg::LABEL_W'(mtc_pkg::CAT_W'(c) + mtc_pkg::CAT_W'(1));
      out_count <= mtc_pkg::sat_out(rd_data);
      out_last  <= r_end && c_end;
    end
  end

endmodule

>>> src/markov_transition_counter.sv
`timescale 1ns / 1ps

// Markov transition counter. Each sample request carries a category code, a
// missing flag and an imputed code; a missing sample takes the imputed code.
// Every consecutive pair of codes that both lie in 1..n (n as below) bumps a
// saturating count at (previous, current) in a 64-entry count memory with a
// registered read. Non-final samples are taken back to back: a read is issued
// at acceptance and the write-back happens in the next cycle, overlapped with
// the next request, with forwarding when both touch the same entry. The sample
// marked end_of_sequence is followed by a readout of n*n result requests in
// row-major order (n is category_count limited to the matrix size), each
// carrying the sequence's first code, with last_entry on the final one. The
// readout takes one memory read per entry: it passes through READ, LOAD and
// SEND for the first result, then alternates LOAD and SEND while the sink is
// ready. No samples are taken during the readout. The matrix clears as the
// last result leaves (at once for n = 0), so no sweep is needed, and the next
// sample starts a new sequence. Write category_count only while the block is
// idle; the configuration channel is always ready.
module markov_transition_counter (
  input  logic      clk,
  input  logic      rst,
  mtc_cfg_if.sink   cfg,
  mtc_in_if.sink    samples,
  mtc_out_if.source results
);

  logic [mtc_pkg::CFG_W-1:0]      category_count;
  logic [mtc_pkg::CAT_W-1:0]      n;

  mtc_pkg::rd_req_t               up_rd;
  mtc_pkg::rd_req_t               ro_rd;
  mtc_pkg::rd_req_t               rd;
  mtc_pkg::wr_req_t               wr;
  mtc_pkg::start_t                start;
  logic                           ro_busy;
  logic                           clear;
  logic [mtc_pkg::COUNT_BITS-1:0] rd_data;

  // Configuration: one register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      category_count <= mtc_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      category_count <= cfg.category_count;
    end
  end

  // Limit the category count to the matrix size
  always_comb begin
    if (32'(category_count) > mtc_pkg::MAX_CATEGORIES) begin
      n = mtc_pkg::CAT_W'(mtc_pkg::MAX_CATEGORIES);
    end else begin
      n = mtc_pkg::CAT_W'(category_count);
    end
  end

  // The read port belongs to the readout while it runs; no sample is taken then
  assign rd = ro_busy ? ro_rd : up_rd;

  mtc_update u_update (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .n       (n),
    .ro_busy (ro_busy),
    .rd_data (rd_data),
    .rd      (up_rd),
    .wr      (wr),
    .start   (start)
  );

  mtc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .clear   (clear),
    .rd_data (rd_data)
  );

  mtc_readout u_readout (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .rd_data (rd_data),
    .rd      (ro_rd),
    .clear   (clear),
    .busy    (ro_busy),
    .results (results)
  );

endmodule

>>> src/mtc_checker.sv
`timescale 1ns / 1ps

module mtc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mtc_pkg::LABEL_W-1:0]  out_from,
  input logic [mtc_pkg::LABEL_W-1:0]  out_to,
  input logic [mtc_pkg::PAIR_W-1:0]   out_count,
  input logic                         out_last
);

  // No sample is taken while a readout is under way
  a_no_sample_in_readout: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("sample accepted during readout");

  // The final entry sits on the diagonal
  a_last_on_diagonal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_from == out_to))
    else $error("last entry off the diagonal");

  // The readout ends with its last entry
  a_readout_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result after last entry");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count) && $stable(out_from)
                                   && $stable(out_to) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind markov_transition_counter mtc_checker u_mtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_from  (results.from_category),
  .out_to    (results.to_category),
  .out_count (results.pair_count),
  .out_last  (results.last_entry)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the Markov transition counter.
// Sample requests go in on one channel and matrix entries come back on
// another; a cycle-free predictor follows every accepted sample request and
// queues the entries it expects, and the result monitor pops and compares
// them in order. Directed tests hit the code and count corner cases, then
// random sequences run under several sender and receiver idling mixes.
module testbench;

  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [mtc_pkg::LABEL_W-1:0] from_cat;
    logic [mtc_pkg::LABEL_W-1:0] to_cat;
    logic [mtc_pkg::PAIR_W-1:0]  count;
    logic [mtc_pkg::CODE_W-1:0]  first;
    logic                        last;
  } matrix_entry_t;

  logic clk;
  logic rst;

  mtc_cfg_if cfg_if();
  mtc_in_if  samples_if();
  mtc_out_if results_if();

  markov_transition_counter DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .samples (samples_if),
    .results (results_if)
  );

  // Predictor copy of the block's state and its one register.
  logic [mtc_pkg::COUNT_BITS-1:0] tally [mtc_pkg::DEPTH];
  logic [mtc_pkg::CODE_W-1:0]     prev_code;
  logic [mtc_pkg::CODE_W-1:0]     seq_first;
  logic                           have_prev;
  logic [mtc_pkg::CFG_W-1:0]      cat_count;

  matrix_entry_t readout_q[$];

  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int hold_requests;
  int hold_taken;

  // Run the clock: low first, 12 ns period.
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[markov_transition_counter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic int active_n();
    return (int'(cat_count) > mtc_pkg::MAX_CATEGORIES) ? mtc_pkg::MAX_CATEGORIES
                                                       : int'(cat_count);
  endfunction

  function automatic void clear_matrix();
    foreach (tally[i]) tally[i] = '0;
    prev_code = '0;
    seq_first = '0;
    have_prev = 1'b0;
  endfunction

  // Fold one accepted sample request into the matrix and, on the end of a
  // sequence, queue the n*n entries of the readout.
  function automatic void predict_sample(input logic [mtc_pkg::CODE_W-1:0] smp,
                                         input logic miss,
                                         input logic [mtc_pkg::CODE_W-1:0] imp,
                                         input logic eos);
    int                         n;
    int                         addr;
    logic [mtc_pkg::CODE_W-1:0] code;
    logic [mtc_pkg::WIDE_W-1:0] wide;
    matrix_entry_t              e;
    n    = active_n();
    code = miss ? imp : smp;
    if (!have_prev) begin
      seq_first = code;
    end else if (prev_code >= 1 && prev_code <= n && code >= 1 && code <= n) begin
      addr = (int'(prev_code) - 1) * mtc_pkg::MAX_CATEGORIES + int'(code) - 1;
      if (tally[addr] != mtc_pkg::COUNT_MAX) begin
        tally[addr] = tally[addr] + mtc_pkg::COUNT_BITS'(1);
      end
    end
    prev_code = code;
    have_prev = 1'b1;
    if (eos) begin
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          wide       = mtc_pkg::WIDE_W'(tally[r * mtc_pkg::MAX_CATEGORIES + c]);
          e.from_cat = mtc_pkg::LABEL_W'(r + 1);
          e.to_cat   = mtc_pkg::LABEL_W'(c + 1);
          e.count    = (wide > mtc_pkg::WIDE_W'({mtc_pkg::PAIR_W{1'b1}})) ? '1
                                                                           : mtc_pkg::PAIR_W'(wide);
          e.first    = seq_first;
          e.last     = (r == n - 1) && (c == n - 1);
          readout_q  = {readout_q, e};
        end
      end
      clear_matrix();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side: ready pattern, hold-off counter and the checker
  // ---------------------------------------------------------------------

  // Drop ready at random, and hard while a hold-off is running.
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Start a receiver hold-off on request and count it down.
  always @(negedge clk) begin
    if (hold_requests != hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_requests;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Compare every accepted result request with the oldest expected entry.
  always @(posedge clk) begin : check_results
    matrix_entry_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (readout_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual (%0d,%0d) count %0d",
                 $time, results_if.from_category, results_if.to_category,
                 results_if.pair_count);
      end else begin
        want = readout_q.pop_front();
        if (results_if.from_category !== want.from_cat)
          report_field("from_category", int'(want.from_cat), int'(results_if.from_category));
        if (results_if.to_category !== want.to_cat)
          report_field("to_category", int'(want.to_cat), int'(results_if.to_category));
        if (results_if.pair_count !== want.count)
          report_field("pair_count", int'(want.count), int'(results_if.pair_count));
        if (results_if.first_code !== want.first)
          report_field("first_code", int'(want.first), int'(results_if.first_code));
        if (results_if.last_entry !== want.last)
          report_field("last_entry", int'(want.last), int'(results_if.last_entry));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sample and configuration drivers
  // ---------------------------------------------------------------------

  // Idle at random, offer one sample request at the falling edge and hold it
  // until the block takes it. Leave valid high so back-to-back requests need
  // no gap.
  task automatic send_sample(input logic [mtc_pkg::CODE_W-1:0] smp, input logic miss,
                             input logic [mtc_pkg::CODE_W-1:0] imp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      samples_if.valid <= 1'b0;
    end
    @(negedge clk);
    samples_if.valid           <= 1'b1;
    samples_if.sample_code     <= smp;
    samples_if.is_missing      <= miss;
    samples_if.imputed_code    <= imp;
    samples_if.end_of_sequence <= eos;
    do @(posedge clk); while (!samples_if.ready);
    predict_sample(smp, miss, imp, eos);
  endtask

  // Carry an effective code either directly or through the imputed field,
  // with random junk in the unused field.
  task automatic send_element(input logic [mtc_pkg::CODE_W-1:0] code, input logic eos);
    if ($urandom_range(3) == 0) begin
      send_sample(mtc_pkg::CODE_W'($urandom_range(255)), 1'b1, code, eos);
    end else begin
      send_sample(code, 1'b0, mtc_pkg::CODE_W'($urandom_range(255)), eos);
    end
  endtask

  // Lower valid, wait out every expected entry, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write category_count; call only while the block is idle.
  task automatic write_category_count(input logic [mtc_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.category_count <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cat_count = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly codes inside 1..n, sometimes zero, above n or anything at all.
  function automatic logic [mtc_pkg::CODE_W-1:0] pick_code(input int n);
    int roll;
    roll = $urandom_range(99);
    if (n == 0 || roll < 8) return mtc_pkg::CODE_W'($urandom_range(255));
    if (roll < 12) return '0;
    if (roll < 16) return mtc_pkg::CODE_W'($urandom_range(255, n + 1));
    return mtc_pkg::CODE_W'($urandom_range(n, 1));
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset count of 8: extreme codes, a missing sample, an out-of-range code
  // breaking a pair, and the end sample contributing its own pair.
  task automatic test_code_extremes();
    send_sample(8'd1,   1'b0, 8'hFF, 1'b0);
    send_sample(8'd8,   1'b0, 8'h00, 1'b0);
    send_sample(8'd0,   1'b1, 8'd8,  1'b0);
    send_sample(8'd255, 1'b0, 8'h00, 1'b0);
    send_sample(8'd3,   1'b0, 8'hFF, 1'b0);
    send_sample(8'hAA,  1'b1, 8'd3,  1'b1);
    wait_idle();
  endtask

  // A one-element sequence with an imputed zero, then a fresh sequence.
  task automatic test_lone_element();
    send_sample(8'd5, 1'b1, 8'd0, 1'b1);
    send_sample(8'd2, 1'b0, 8'd0, 1'b0);
    send_sample(8'd2, 1'b0, 8'd0, 1'b1);
    wait_idle();
  endtask

  // Count of zero gives an empty readout but still clears; count of one;
  // counts above the matrix size saturate to eight.
  task automatic test_count_extremes();
    write_category_count(4'd0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b1);
    wait_idle();
    write_category_count(4'd1);
    send_sample(8'd1, 1'b0, 8'd0, 1'b0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b0);
    send_sample(8'd2, 1'b0, 8'd0, 1'b0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b1);
    wait_idle();
    write_category_count(4'd15);
    send_sample(8'd8, 1'b0, 8'd0, 1'b0);
    send_sample(8'd7, 1'b0, 8'd0, 1'b1);
    wait_idle();
  endtask

  // Shrink the count inside a sequence: counts outside the new range stay
  // hidden in the readout and are gone after the clear.
  task automatic test_count_change_mid_sequence();
    write_category_count(4'd8);
    send_sample(8'd5, 1'b0, 8'd0, 1'b0);
    send_sample(8'd5, 1'b0, 8'd0, 1'b0);
    send_sample(8'd4, 1'b0, 8'd0, 1'b0);
    wait_idle();
    write_category_count(4'd4);
    send_sample(8'd4, 1'b0, 8'd0, 1'b0);
    send_sample(8'd1, 1'b0, 8'd0, 1'b1);
    wait_idle();
    write_category_count(4'd8);
    send_sample(8'd2, 1'b0, 8'd0, 1'b0);
    send_sample(8'd2, 1'b0, 8'd0, 1'b1);
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering requests, so the readout stalls and the input backs up.
  task automatic test_backpressure();
    write_category_count(4'd2);
    hold_requests++;
    send_sample(8'd1, 1'b0, 8'd0, 1'b0);
    send_sample(8'd2, 1'b0, 8'd0, 1'b1);
    for (int i = 0; i < 20; i++) begin
      send_element(pick_code(2), i == 19);
    end
    wait_idle();
  endtask

  // Random sequences of random length under one idling mix and count.
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items,
                                  input logic [mtc_pkg::CFG_W-1:0] count);
    int sent;
    int len;
    bit noisy;
    write_category_count(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len   = $urandom_range(12, 1);
      noisy = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
        send_element(noisy ? mtc_pkg::CODE_W'($urandom_range(255)) : pick_code(active_n()),
                     i == len - 1);
      end
      sent += len;
    end
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(0,  0,  80, 4'd8);
    run_random_phase(86, 0,  80, mtc_pkg::CFG_W'($urandom_range(15, 1)));
    run_random_phase(0,  86, 80, 4'd3);
    run_random_phase(28, 28, 80, mtc_pkg::CFG_W'($urandom_range(7, 2)));
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------

  initial begin
    rst                        = 1'b1;
    samples_if.valid           = 1'b0;
    samples_if.sample_code     = '0;
    samples_if.is_missing      = 1'b0;
    samples_if.imputed_code    = '0;
    samples_if.end_of_sequence = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.category_count      = '0;
    send_idle_pct              = 0;
    recv_stall_pct             = 0;
    hold_requests              = 0;
    cat_count                  = mtc_pkg::CFG_RESET;
    clear_matrix();

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_code_extremes();
    test_lone_element();
    test_count_extremes();
    test_count_change_mid_sequence();
    test_backpressure();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("[markov_transition_counter] OK");
    end else begin
      $display("[markov_transition_counter] ERROR");
    end
    $finish;
  end

endmodule
